FILE: design/ptc_pkg.sv
// package for the pressure and temperature compensation block
// holds beat types, register indexes and shared constants; no dependencies
package ptc_pkg;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFFS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_P1_P2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_P3_P4 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_P5_P6 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_P7_P8 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_P9    = 3'd5;

	// arithmetic constants of the compensation formula
	localparam logic [63:0] T_FINE_OFFSET = 64'd128000;
	localparam logic [63:0] PRESS_FULL    = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE   = 64'd3125;
	localparam logic [63:0] VAR1_BIAS     = 64'h0000_8000_0000_0000;
	localparam logic [31:0] TEMP_ROUND    = 32'd128;

	// divider geometry
	localparam int unsigned DIV_W   = 64;
	localparam int unsigned DIV_LAT = DIV_W + 2;

	// pipeline depth of the wide multiplier
	localparam int unsigned MUL_LAT = 2;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
	} ptc_in_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
		logic               pressure_valid;
	} ptc_out_t;

endpackage

FILE: design/ptc_delay.sv
// delay line of fixed depth with a common advance enable
// depends on nothing
module ptc_delay #(
	parameter int unsigned W = 1,
	parameter int unsigned D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] tap_s [0:D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s[0] <= '0;
		end else if (en) begin
			tap_s[0] <= d;
		end
	end

	for (genvar k = 1; k < D; k++) begin : g_tap
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tap_s[k] <= '0;
			end else if (en) begin
				tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign q = tap_s[D-1];
endmodule

FILE: design/ptc_mul64.sv
// low 64 bits of a 64 by 64 product, two stages of 32 by 32 partial products
// depends on nothing; sign-agnostic (wraps)
module ptc_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [31:0] lh;
	logic [31:0] hl;

	assign lh = a[31:0] * b[63:32];
	assign hl = a[63:32] * b[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			lh_s1 <= lh;
			hl_s1 <= hl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= ll_s1 + {lh_s1 + hl_s1, 32'd0};
		end
	end
endmodule

FILE: design/ptc_sdiv.sv
// pipelined signed 64-bit divider, truncating toward zero, one quotient bit per stage
// depends on ptc_pkg (DIV_W); registers the magnitudes, each quotient bit, then the sign
module ptc_sdiv (
	input  logic                      clk,
	input  logic                      en,
	input  logic [ptc_pkg::DIV_W-1:0] num,
	input  logic [ptc_pkg::DIV_W-1:0] den,
	output logic [ptc_pkg::DIV_W-1:0] quo
);
	import ptc_pkg::*;

	logic [DIV_W-1:0] rem_s [0:DIV_W-1];
	logic [DIV_W-1:0] quo_s [0:DIV_W];
	logic [DIV_W-1:0] dvs_s [0:DIV_W-1];
	logic             neg_s [0:DIV_W];

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			quo_s[0] <= num[DIV_W-1] ? -num : num;
			dvs_s[0] <= den[DIV_W-1] ? -den : den;
			neg_s[0] <= num[DIV_W-1] ^ den[DIV_W-1];
		end
	end

	for (genvar k = 0; k < DIV_W; k++) begin : g_step
		logic [DIV_W-1:0] shl;
		logic [DIV_W:0]   diff;

		assign shl  = {rem_s[k][DIV_W-2:0], quo_s[k][DIV_W-1]};
		assign diff = {1'b0, shl} - {1'b0, dvs_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k+1] <= {quo_s[k][DIV_W-2:0], ~diff[DIV_W]};
				neg_s[k+1] <= neg_s[k];
			end
		end

		if (k < DIV_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= diff[DIV_W] ? shl : diff[DIV_W-1:0];
					dvs_s[k+1] <= dvs_s[k];
				end
			end
		end
	end

	// restore sign
	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[DIV_W] ? -quo_s[DIV_W] : quo_s[DIV_W];
		end
	end
endmodule

FILE: design/pressure_temperature_compensation.sv
// top level of the pressure and temperature compensation pipeline
// depends on ptc_pkg, ptc_delay, ptc_mul64 and ptc_sdiv
//
// usage
//  - sample channel (sample_valid / sample_ready / sample) takes one beat of
//    raw pressure and raw temperature readings, 20 bits each
//  - result channel (result_valid / result_ready / result) gives one beat per
//    sample: temperature in centidegrees, pressure in q24.8 pascals and a flag
//    that is clear when the pressure divisor came out as zero
//  - coefficients are loaded through cfg_we / cfg_index / cfg_data while no
//    sample is in flight; unknown indexes are ignored
//  - one sample per cycle is taken while the pipeline is not held; the
//    divider works out one quotient bit per stage
//  - reset clears the coefficients and all valid bits; the pipeline is empty
//  - when result_ready is low with a result waiting, the whole pipeline holds
//    and sample_ready drops; nothing is lost or repeated, and bubbles keep
//    moving forward while the output slot is empty
module pressure_temperature_compensation (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  ptc_pkg::ptc_in_t                  sample,
	output logic                              result_valid,
	input  logic                              result_ready,
	output ptc_pkg::ptc_out_t                 result,
	input  logic                              cfg_we,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ptc_pkg::*;

	function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [63:0] sext16(input logic [15:0] x);
		return {{48{x[15]}}, x};
	endfunction

	// coefficient registers
	logic [47:0] temp_coeffs_q;
	logic [31:0] p12_q;
	logic [31:0] p34_q;
	logic [31:0] p56_q;
	logic [31:0] p78_q;
	logic [15:0] p9_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			p12_q         <= '0;
			p34_q         <= '0;
			p56_q         <= '0;
			p78_q         <= '0;
			p9_q          <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP_COEFFS: temp_coeffs_q <= cfg_data[47:0];
				REG_PRESS_P1_P2: p12_q         <= cfg_data[31:0];
				REG_PRESS_P3_P4: p34_q         <= cfg_data[31:0];
				REG_PRESS_P5_P6: p56_q         <= cfg_data[31:0];
				REG_PRESS_P7_P8: p78_q         <= cfg_data[31:0];
				REG_PRESS_P9:    p9_q          <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// coefficients widened to their working sizes
	logic [31:0] t1c, t2c, t3c;
	logic [63:0] p1e, p2e, p3e, p4e, p5e, p6e, p7e, p8e, p9e;

	assign t1c = {16'd0, temp_coeffs_q[15:0]};
	assign t2c = {{16{temp_coeffs_q[31]}}, temp_coeffs_q[31:16]};
	assign t3c = {{16{temp_coeffs_q[47]}}, temp_coeffs_q[47:32]};
	assign p1e = {48'd0, p12_q[15:0]};
	assign p2e = sext16(p12_q[31:16]);
	assign p3e = sext16(p34_q[15:0]);
	assign p4e = sext16(p34_q[31:16]);
	assign p5e = sext16(p56_q[15:0]);
	assign p6e = sext16(p56_q[31:16]);
	assign p7e = sext16(p78_q[15:0]);
	assign p8e = sext16(p78_q[31:16]);
	assign p9e = sext16(p9_q);

	// global advance: the pipeline moves unless a result sits unaccepted
	logic adv;
	assign adv          = !result_valid || result_ready;
	assign sample_ready = adv;

	// beat valid travels the full depth alongside the data
	ptc_delay #(.W(1), .D(85)) u_vld (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(sample_valid), .q(result_valid)
	);

	// stage 1: capture the readings
	logic [19:0] adc_t_s1, adc_p_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			adc_t_s1 <= sample.raw_temperature;
			adc_p_s1 <= sample.raw_pressure;
		end
	end

	// temperature, 32-bit wrap
	logic [31:0] x1, dt, dtsh;
	logic [31:0] a1p_s2, dtsq_s2;
	logic [31:0] a1_s3, a2p_s3;
	logic [31:0] tfine_s4;
	logic [31:0] temp_s5;
	logic [63:0] v1_s5;

	assign x1   = 32'(adc_t_s1[19:3]) - {t1c[30:0], 1'b0};
	assign dt   = 32'(adc_t_s1[19:4]) - t1c;
	assign dtsh = asr32(dtsq_s2, 5'd12);

	always_ff @(posedge clk) begin
		if (adv) begin
			a1p_s2   <= x1 * t2c;
			dtsq_s2  <= dt * dt;
			a1_s3    <= asr32(a1p_s2, 5'd11);
			a2p_s3   <= dtsh * t3c;
			tfine_s4 <= a1_s3 + asr32(a2p_s3, 5'd14);
			// temperature x100 with rounding: (5 t_fine + 128) / 256
			temp_s5  <= asr32({tfine_s4[29:0], 2'b00} + tfine_s4 + TEMP_ROUND, 5'd8);
			v1_s5    <= {{32{tfine_s4[31]}}, tfine_s4} - T_FINE_OFFSET;
		end
	end

	// pressure, first products of var1
	logic [63:0] sq_s7, v1p5_s7, v1p2_s7;

	ptc_mul64 u_mul_sq (.clk(clk), .en(adv), .a(v1_s5), .b(v1_s5), .p(sq_s7));
	ptc_mul64 u_mul_p5 (.clk(clk), .en(adv), .a(v1_s5), .b(p5e),   .p(v1p5_s7));
	ptc_mul64 u_mul_p2 (.clk(clk), .en(adv), .a(v1_s5), .b(p2e),   .p(v1p2_s7));

	logic [63:0] sqp6_s9, sqp3_s9, v1p5_s9, v1p2_s9;

	ptc_mul64 u_mul_p6 (.clk(clk), .en(adv), .a(sq_s7), .b(p6e), .p(sqp6_s9));
	ptc_mul64 u_mul_p3 (.clk(clk), .en(adv), .a(sq_s7), .b(p3e), .p(sqp3_s9));

	ptc_delay #(.W(64), .D(MUL_LAT)) u_dly_v1p5 (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(v1p5_s7), .q(v1p5_s9)
	);
	ptc_delay #(.W(64), .D(MUL_LAT)) u_dly_v1p2 (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(v1p2_s7), .q(v1p2_s9)
	);

	// raw pressure waits for var2
	logic [19:0] adc_p_s10;

	ptc_delay #(.W(20), .D(9)) u_dly_adcp (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(adc_p_s1), .q(adc_p_s10)
	);

	// stage 10: var2 and the second var1 sum
	logic [63:0] v2_s10, va_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			v2_s10 <= sqp6_s9 + (v1p5_s9 << 17) + (p4e << 35);
			va_s10 <= asr64(sqp3_s9, 6'd8) + (v1p2_s9 << 12);
		end
	end

	// stage 11: numerator before scaling, biased var1
	logic [63:0] dd_s11, m_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			dd_s11 <= ((PRESS_FULL - 64'(adc_p_s10)) << 31) - v2_s10;
			m_s11  <= VAR1_BIAS + va_s10;
		end
	end

	logic [63:0] num_s13, m1_s13, den;

	ptc_mul64 u_mul_scale (.clk(clk), .en(adv), .a(dd_s11), .b(PRESS_SCALE), .p(num_s13));
	ptc_mul64 u_mul_p1    (.clk(clk), .en(adv), .a(m_s11),  .b(p1e),         .p(m1_s13));

	assign den = asr64(m1_s13, 6'd33);

	// zero divisor flag and temperature ride along to the output stage
	logic        zero_s84;
	logic [31:0] temp_s84;

	ptc_delay #(.W(1), .D(71)) u_dly_zero (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(den == 64'd0), .q(zero_s84)
	);
	ptc_delay #(.W(32), .D(79)) u_dly_temp (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(temp_s5), .q(temp_s84)
	);

	// division, stages 14 to 79
	logic [63:0] pq_s79;

	ptc_sdiv u_div (.clk(clk), .en(adv), .num(num_s13), .den(den), .quo(pq_s79));

	// final corrections
	logic [63:0] ph_s79, ph_s81, w1a_s81, w2p_s81, w1p_s83, w2p_s83, pq_s83;

	assign ph_s79 = asr64(pq_s79, 6'd13);

	ptc_mul64 u_mul_p9 (.clk(clk), .en(adv), .a(p9e), .b(ph_s79), .p(w1a_s81));
	ptc_mul64 u_mul_p8 (.clk(clk), .en(adv), .a(p8e), .b(pq_s79), .p(w2p_s81));

	ptc_delay #(.W(64), .D(MUL_LAT)) u_dly_ph (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(ph_s79), .q(ph_s81)
	);

	ptc_mul64 u_mul_ph (.clk(clk), .en(adv), .a(w1a_s81), .b(ph_s81), .p(w1p_s83));

	ptc_delay #(.W(64), .D(MUL_LAT)) u_dly_w2 (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(w2p_s81), .q(w2p_s83)
	);
	ptc_delay #(.W(64), .D(2 * MUL_LAT)) u_dly_pq (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(pq_s79), .q(pq_s83)
	);

	// stage 84: sum of the quotient and both corrections
	logic [63:0] sum_s84;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s84 <= pq_s83 + asr64(w1p_s83, 6'd25) + asr64(w2p_s83, 6'd19);
		end
	end

	// stage 85: scale, offset by p7, clamp to 32 bits
	logic [63:0] pf;
	logic [31:0] press;

	assign pf = asr64(sum_s84, 6'd8) + (p7e << 4);

	always_comb begin
		if (pf[63]) begin
			press = '0;
		end else if (pf[62:32] != '0) begin
			press = '1;
		end else begin
			press = pf[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.temperature_centi <= temp_s84;
			result.pressure_q24_8    <= zero_s84 ? 32'd0 : press;
			result.pressure_valid    <= !zero_s84;
		end
	end
endmodule
